### rtl/tsss_pkg.sv
// Shared types, constants and lookup functions for the temperature display serializer.
package tsss_pkg;

  // Depth of the queue between the conversion front and the serializer back.
  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  localparam int unsigned FRAME_BITS = 16;
  localparam int unsigned BIT_W      = $clog2(FRAME_BITS);
  localparam int unsigned DIGIT_W    = 4;

  localparam int unsigned SAMPLE_W = 10;
  localparam int unsigned PROD_W   = 18;
  localparam int unsigned TEMP_W   = 8;

  localparam logic [7:0]  CEL_NUM    = 8'd110;
  localparam logic [7:0]  FAH_NUM    = 8'd198;
  localparam logic [7:0]  FAH_OFFSET = 8'd32;
  localparam logic [10:0] ADC_DEN    = 11'd1023;

  localparam int unsigned PADDR_W = 3;
  localparam int unsigned PDATA_W = 32;

  typedef enum logic {
    REG_UNIT_FAHRENHEIT = 1'b0,
    REG_NONE            = 1'b1
  } reg_idx_e;

  typedef struct packed {
    logic              nonempty;
    logic [QCNT_W-1:0] level;
  } q_status_t;

  function automatic logic [7:0] seg_code(input logic [DIGIT_W-1:0] digit);
    logic [7:0] code;
    unique case (digit)
      4'd0:    code = 8'h03;
      4'd1:    code = 8'h9F;
      4'd2:    code = 8'h25;
      4'd3:    code = 8'h0D;
      4'd4:    code = 8'h99;
      4'd5:    code = 8'h49;
      4'd6:    code = 8'h41;
      4'd7:    code = 8'h1F;
      4'd8:    code = 8'h01;
      4'd9:    code = 8'h09;
      default: code = 8'hFF;
    endcase
    return code;
  endfunction

  // Digit i drives select line 4+i of the external shift register.
  function automatic logic [7:0] sel_byte(input logic [1:0] pos);
    return 8'b0001_0000 << pos;
  endfunction

endpackage

### rtl/tsss_front.sv
// Front end: accepts samples, converts them to a temperature and splits it into digits.
module tsss_front #(
  parameter int unsigned NUM_DIGITS = 4
) (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic                                     start_i,
  input  logic [tsss_pkg::SAMPLE_W-1:0]            sample_i,
  input  logic                                     unit_i,
  input  tsss_pkg::q_status_t                      q_status_i,
  output logic                                     busy_o,
  output logic                                     push_o,
  output logic [NUM_DIGITS*tsss_pkg::DIGIT_W-1:0]  push_data_o
);

  localparam int unsigned OCC_W = tsss_pkg::QCNT_W + 1;

  logic                          v1_q, v1_d;
  logic                          v2_q, v2_d;
  logic [tsss_pkg::PROD_W-1:0]   prod_q, prod_d;
  logic                          unit1_q, unit1_d;
  logic [tsss_pkg::TEMP_W-1:0]   temp_q, temp_d;
  logic                          accept;
  logic [OCC_W-1:0]              occ;
  logic [7:0]                    quo0;
  logic [10:0]                   rem0;
  logic [7:0]                    quo;
  logic [1:0]                    hundreds;
  logic [6:0]                    rest;
  logic [14:0]                   tens_prod;
  logic [3:0]                    tens;
  logic [3:0]                    units;
  logic [4*tsss_pkg::DIGIT_W-1:0] all_digits;

  // Items in the pipeline count against queue space, so a push never overflows.
  assign occ    = OCC_W'(v1_q) + OCC_W'(v2_q) + OCC_W'(q_status_i.level);
  assign busy_o = (occ >= OCC_W'(tsss_pkg::QDEPTH));
  assign accept = start_i && !busy_o;

  always_comb begin
    unit1_d = unit_i;
    prod_d  = tsss_pkg::PROD_W'(sample_i) *
              tsss_pkg::PROD_W'(unit_i ? tsss_pkg::FAH_NUM : tsss_pkg::CEL_NUM);
    v1_d    = accept;
  end

  // x / 1023: with x = 1024*q0 + low, the remainder is low + q0, off by one step at most.
  always_comb begin
    quo0   = prod_q[tsss_pkg::PROD_W-1:10];
    rem0   = 11'(prod_q[9:0]) + 11'(quo0);
    quo    = (rem0 >= tsss_pkg::ADC_DEN) ? quo0 + 8'd1 : quo0;
    temp_d = unit1_q ? quo + tsss_pkg::FAH_OFFSET : quo;
    v2_d   = v1_q;
  end

  always_comb begin
    if (temp_q >= 8'd200) begin
      hundreds = 2'd2;
    end else if (temp_q >= 8'd100) begin
      hundreds = 2'd1;
    end else begin
      hundreds = 2'd0;
    end
    rest       = 7'(temp_q - 8'(hundreds) * 8'd100);
    // rest is below 100, where (rest*205)>>11 equals rest/10.
    tens_prod  = 15'(rest) * 15'd205;
    tens       = tens_prod[14:11];
    units      = 4'(rest - 7'(tens) * 7'd10);
    all_digits = {4'd0, 2'b00, hundreds, tens, units};
  end

  assign push_o      = v2_q;
  assign push_data_o = all_digits[NUM_DIGITS*tsss_pkg::DIGIT_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= v1_d;
      v2_q <= v2_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      prod_q  <= prod_d;
      unit1_q <= unit1_d;
    end
    if (v1_q) begin
      temp_q <= temp_d;
    end
  end

endmodule

### rtl/tsss_queue.sv
// Short queue of digit sets between the front end and the serializer.
module tsss_queue #(
  parameter int unsigned DW = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  logic [DW-1:0]       push_data_i,
  input  logic                pop_i,
  output logic [DW-1:0]       head_o,
  output tsss_pkg::q_status_t status_o
);

  logic [DW-1:0]                   mem_q [tsss_pkg::QDEPTH];
  logic [tsss_pkg::QPTR_W-1:0]     wr_ptr_q, wr_ptr_d;
  logic [tsss_pkg::QPTR_W-1:0]     rd_ptr_q, rd_ptr_d;
  logic [tsss_pkg::QCNT_W-1:0]     cnt_q, cnt_d;

  function automatic logic [tsss_pkg::QPTR_W-1:0] ptr_inc(
    input logic [tsss_pkg::QPTR_W-1:0] p
  );
    logic [tsss_pkg::QPTR_W-1:0] n;
    if (p == tsss_pkg::QPTR_W'(tsss_pkg::QDEPTH - 1)) begin
      n = '0;
    end else begin
      n = p + 1'b1;
    end
    return n;
  endfunction

  always_comb begin
    wr_ptr_d = push_i ? ptr_inc(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = pop_i ? ptr_inc(rd_ptr_q) : rd_ptr_q;
    cnt_d    = cnt_q + tsss_pkg::QCNT_W'(push_i) - tsss_pkg::QCNT_W'(pop_i);
  end

  assign head_o            = mem_q[rd_ptr_q];
  assign status_o.nonempty = (cnt_q != '0);
  assign status_o.level    = cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

### rtl/tsss_back.sv
// Back end: shifts out segment and select bytes for each digit, one bit per cycle.
module tsss_back #(
  parameter int unsigned NUM_DIGITS = 4
) (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  tsss_pkg::q_status_t                      q_status_i,
  input  logic [NUM_DIGITS*tsss_pkg::DIGIT_W-1:0]  q_head_i,
  output logic                                     pop_o,
  output logic                                     valid_o,
  output logic                                     serial_bit_o,
  output logic                                     latch_pulse_o,
  output logic                                     last_o
);

  localparam int unsigned DW    = NUM_DIGITS * tsss_pkg::DIGIT_W;
  localparam int unsigned DIG_W = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;

  logic                          active_q, active_d;
  logic [DIG_W-1:0]              digit_q, digit_d;
  logic [tsss_pkg::BIT_W-1:0]    bit_q, bit_d;
  logic [DW-1:0]                 digits_q, digits_d;
  logic [tsss_pkg::FRAME_BITS-1:0] frame_q, frame_d;
  logic                          frame_end;
  logic                          item_end;
  logic                          load_item;
  logic [DW-1:0]                 digits_next;
  logic [DIG_W-1:0]              digit_next;

  assign frame_end   = active_q && (bit_q == tsss_pkg::BIT_W'(tsss_pkg::FRAME_BITS - 1));
  assign item_end    = frame_end && (digit_q == DIG_W'(NUM_DIGITS - 1));
  // A waiting item starts on the cycle after the previous one's last bit.
  assign load_item   = q_status_i.nonempty && (!active_q || item_end);
  assign digits_next = digits_q >> tsss_pkg::DIGIT_W;
  assign digit_next  = digit_q + 1'b1;

  always_comb begin
    active_d = active_q;
    digit_d  = digit_q;
    bit_d    = bit_q;
    digits_d = digits_q;
    frame_d  = frame_q;
    priority if (load_item) begin
      active_d = 1'b1;
      digit_d  = '0;
      bit_d    = '0;
      digits_d = q_head_i;
      frame_d  = {tsss_pkg::sel_byte(2'd0), tsss_pkg::seg_code(q_head_i[3:0])};
    end else if (item_end) begin
      active_d = 1'b0;
    end else if (frame_end) begin
      digit_d  = digit_next;
      bit_d    = '0;
      digits_d = digits_next;
      frame_d  = {tsss_pkg::sel_byte(2'(digit_next)),
                  tsss_pkg::seg_code(digits_next[3:0])};
    end else if (active_q) begin
      bit_d   = bit_q + 1'b1;
      frame_d = frame_q >> 1;
    end else begin
      active_d = 1'b0;
    end
  end

  assign pop_o         = load_item;
  assign valid_o       = active_q;
  assign serial_bit_o  = frame_q[0];
  assign latch_pulse_o = frame_end;
  assign last_o        = item_end;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      digit_q  <= '0;
      bit_q    <= '0;
    end else begin
      active_q <= active_d;
      digit_q  <= digit_d;
      bit_q    <= bit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    digits_q <= digits_d;
    frame_q  <= frame_d;
  end

endmodule

### rtl/temperature_seven_segment_serializer_top.sv
// Top level of the temperature seven-segment serializer.
//
//   Channel   Signals                               Handshake
//   sample    start, busy, adc_sample_i             taken when start && !busy
//   result    out_valid_o, serial_bit_o,            one bit per strobed cycle
//             latch_pulse_o, last_o
//   config    psel, penable, pwrite, paddr, pwdata,  APB, pready always high
//             prdata, pready
//
// Each sample yields 16*NUM_DIGITS result bits, one per cycle, so the serializer
// sets the rate, with the next sample starting right after the previous last bit.
// The first bit leaves once the request has passed two conversion stages, the
// queue and the frame load.
// Reset clears the pipeline, the queue and the unit register (Celsius).
// The receiver cannot stall; busy rises only when the two-entry queue is spoken for.
module temperature_seven_segment_serializer_top #(
  parameter int unsigned NUM_DIGITS = 4
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start,
  output logic                           busy,
  input  logic [tsss_pkg::SAMPLE_W-1:0]  adc_sample_i,
  output logic                           out_valid_o,
  output logic                           serial_bit_o,
  output logic                           latch_pulse_o,
  output logic                           last_o,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [tsss_pkg::PADDR_W-1:0]   paddr,
  input  logic [tsss_pkg::PDATA_W-1:0]   pwdata,
  output logic [tsss_pkg::PDATA_W-1:0]   prdata,
  output logic                           pready
);

  localparam int unsigned DW = NUM_DIGITS * tsss_pkg::DIGIT_W;

  logic                 unit_q, unit_d;
  tsss_pkg::reg_idx_e   reg_idx;
  logic                 cfg_wr;
  logic                 push;
  logic [DW-1:0]        push_data;
  logic                 pop;
  logic [DW-1:0]        q_head;
  tsss_pkg::q_status_t  q_status;

  assign pready  = 1'b1;
  assign reg_idx = tsss_pkg::reg_idx_e'(paddr[2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_comb begin
    unit_d = unit_q;
    if (cfg_wr && (reg_idx == tsss_pkg::REG_UNIT_FAHRENHEIT)) begin
      unit_d = pwdata[0];
    end
  end

  always_comb begin
    unique case (reg_idx)
      tsss_pkg::REG_UNIT_FAHRENHEIT: prdata = tsss_pkg::PDATA_W'(unit_q);
      default:                       prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      unit_q <= 1'b0;
    end else begin
      unit_q <= unit_d;
    end
  end

  tsss_front #(
    .NUM_DIGITS(NUM_DIGITS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .sample_i    (adc_sample_i),
    .unit_i      (unit_q),
    .q_status_i  (q_status),
    .busy_o      (busy),
    .push_o      (push),
    .push_data_o (push_data)
  );

  tsss_queue #(
    .DW(DW)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .head_o      (q_head),
    .status_o    (q_status)
  );

  tsss_back #(
    .NUM_DIGITS(NUM_DIGITS)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_status_i    (q_status),
    .q_head_i      (q_head),
    .pop_o         (pop),
    .valid_o       (out_valid_o),
    .serial_bit_o  (serial_bit_o),
    .latch_pulse_o (latch_pulse_o),
    .last_o        (last_o)
  );

endmodule

### rtl/tsss_checker.sv
// Port-level checks on the serializer's result stream, bound to the top level.
module tsss_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic out_valid_i,
  input logic latch_pulse_i,
  input logic last_i
);

  // A latch pulse only ever marks a delivered bit.
  a_latch_valid : assert property (@(posedge clk_i) disable iff (!rst_ni)
    latch_pulse_i |-> out_valid_i)
    else $error("latch pulse without a result strobe");

  // The final bit of an item is also the end of a digit frame.
  a_last_latch : assert property (@(posedge clk_i) disable iff (!rst_ni)
    last_i |-> latch_pulse_i)
    else $error("last bit not on a frame boundary");

  // Frames are sixteen bits long, so two latch pulses never touch.
  a_latch_spacing : assert property (@(posedge clk_i) disable iff (!rst_ni)
    latch_pulse_i |=> !latch_pulse_i)
    else $error("latch pulses on adjacent cycles");

  // A frame, once started, is not interrupted.
  a_frame_unbroken : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !latch_pulse_i) |=> out_valid_i)
    else $error("result stream broke off inside a frame");

endmodule

bind temperature_seven_segment_serializer_top tsss_checker u_tsss_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_i   (out_valid_o),
  .latch_pulse_i (latch_pulse_o),
  .last_i        (last_o)
);
